>>> design/hfs_pkg.sv
package hfs_pkg;

    // queue geometry, shared by the task queue and the result queue
    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int QCW    = 4;

    // configuration field widths
    localparam int MU_BITS     = 16;
    localparam int ROWCNT_BITS = 13;
    localparam int COLCNT_BITS = 11;
    localparam int ROW_BITS    = 12;
    localparam int ROW_CAP     = 4096;

    // config port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_MU_ROW    = 2'd0;
    localparam logic [1:0] REG_MU_COL    = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT = 2'd2;
    localparam logic [1:0] REG_COL_COUNT = 2'd3;

    // flags that ride with every result
    typedef struct packed {
        logic bnd;
        logic run_last;
        logic grid_last;
    } t_tag;

endpackage

>>> design/heat_ftcs_stencil_2d.sv
// channel  dir  handshake                      payload
// input    in   push / full                    i_sample
// result   out  pop / empty                    o_value, o_is_boundary, o_run_last, o_grid_last
// config   in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one sample is taken per cycle; full rises only while the task queue holds more than four
// entries, which happens when results are not being popped.
// a result reaches the queue output after the sample that causes it passes the line buffer
// read, the task push and three arithmetic stages; the last column yields two.
// the line buffer has one read and one write port a cycle and no clearing pass.
// reset is synchronous and active low; clears counters, queue pointers, mu; grid size to 3x3
module heat_ftcs_stencil_2d #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    output logic                           empty,
    input  logic                           pop,
    output logic [SAMPLE_BITS-1:0]         o_value,
    output logic                           o_is_boundary,
    output logic                           o_run_last,
    output logic                           o_grid_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfs_pkg::APB_AW-1:0]     paddr,
    input  logic [hfs_pkg::APB_DW-1:0]     pwdata,
    output logic [hfs_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int SB = SAMPLE_BITS;

    logic [hfs_pkg::MU_BITS-1:0]     r_mu_row, r_mu_col;
    logic [hfs_pkg::ROWCNT_BITS-1:0] r_row_count;
    logic [hfs_pkg::COLCNT_BITS-1:0] r_col_count;
    logic                            w_cfg_we;

    logic                       w_tq_we0, w_tq_we1, w_tq_pop;
    hfs_pkg::t_tag              w_tq_tag0, w_tq_tag1, w_tq_tag;
    logic [5*SB-1:0]            w_tq_data0, w_tq_data1, w_tq_data;
    logic [hfs_pkg::QCW-1:0]    w_task_count;

    logic                       w_oq_we;
    hfs_pkg::t_tag              w_oq_tag_in, w_oq_tag;
    logic [SB-1:0]              w_oq_value;
    logic [hfs_pkg::QCW-1:0]    w_out_count;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_row    <= '0;
            r_mu_col    <= '0;
            r_row_count <= hfs_pkg::ROWCNT_BITS'(3);
            r_col_count <= hfs_pkg::COLCNT_BITS'(3);
        end else if (w_cfg_we) begin
            unique case (paddr[3:2])
                hfs_pkg::REG_MU_ROW:    r_mu_row    <= pwdata[hfs_pkg::MU_BITS-1:0];
                hfs_pkg::REG_MU_COL:    r_mu_col    <= pwdata[hfs_pkg::MU_BITS-1:0];
                hfs_pkg::REG_ROW_COUNT: r_row_count <= pwdata[hfs_pkg::ROWCNT_BITS-1:0];
                hfs_pkg::REG_COL_COUNT: r_col_count <= pwdata[hfs_pkg::COLCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hfs_pkg::REG_MU_ROW:    prdata = hfs_pkg::APB_DW'(r_mu_row);
            hfs_pkg::REG_MU_COL:    prdata = hfs_pkg::APB_DW'(r_mu_col);
            hfs_pkg::REG_ROW_COUNT: prdata = hfs_pkg::APB_DW'(r_row_count);
            hfs_pkg::REG_COL_COUNT: prdata = hfs_pkg::APB_DW'(r_col_count);
            default:                prdata = '0;
        endcase
    end

    hfs_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_sample     (i_sample),
        .i_row_count  (r_row_count),
        .i_col_count  (r_col_count),
        .i_task_count (w_task_count),
        .o_we0        (w_tq_we0),
        .o_we1        (w_tq_we1),
        .o_tag0       (w_tq_tag0),
        .o_tag1       (w_tq_tag1),
        .o_data0      (w_tq_data0),
        .o_data1      (w_tq_data1)
    );

    hfs_queue #(
        .W (5 * SB)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we0   (w_tq_we0),
        .i_we1   (w_tq_we1),
        .i_tag0  (w_tq_tag0),
        .i_tag1  (w_tq_tag1),
        .i_data0 (w_tq_data0),
        .i_data1 (w_tq_data1),
        .i_pop   (w_tq_pop),
        .o_count (w_task_count),
        .o_tag   (w_tq_tag),
        .o_data  (w_tq_data)
    );

    hfs_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mu_row     (r_mu_row),
        .i_mu_col     (r_mu_col),
        .i_task_count (w_task_count),
        .i_tag        (w_tq_tag),
        .i_data       (w_tq_data),
        .o_pop        (w_tq_pop),
        .i_out_count  (w_out_count),
        .o_we         (w_oq_we),
        .o_tag        (w_oq_tag_in),
        .o_value      (w_oq_value)
    );

    hfs_queue #(
        .W (SB)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we0   (w_oq_we),
        .i_we1   (1'b0),
        .i_tag0  (w_oq_tag_in),
        .i_tag1  (w_oq_tag_in),
        .i_data0 (w_oq_value),
        .i_data1 (w_oq_value),
        .i_pop   (pop && !empty),
        .o_count (w_out_count),
        .o_tag   (w_oq_tag),
        .o_data  (o_value)
    );

    assign empty         = (w_out_count == '0);
    assign o_is_boundary = w_oq_tag.bnd;
    assign o_run_last    = w_oq_tag.run_last;
    assign o_grid_last   = w_oq_tag.grid_last;

    // credit scheme keeps both queues from overflowing
    a_task_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_task_count <= hfs_pkg::QCW'(hfs_pkg::QDEPTH))
        else $error("task queue overflow");

    a_out_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_count <= hfs_pkg::QCW'(hfs_pkg::QDEPTH))
        else $error("result queue overflow");

    // the frame's last point is always an edge point closing its transaction
    a_grid_last_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_grid_last) |-> (o_is_boundary && o_run_last))
        else $error("grid_last on a non-boundary or non-final result");

endmodule

>>> design/hfs_queue.sv
module hfs_queue #(
    parameter int W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we0,
    input  logic                    i_we1,
    input  hfs_pkg::t_tag           i_tag0,
    input  hfs_pkg::t_tag           i_tag1,
    input  logic [W-1:0]            i_data0,
    input  logic [W-1:0]            i_data1,
    input  logic                    i_pop,
    output logic [hfs_pkg::QCW-1:0] o_count,
    output hfs_pkg::t_tag           o_tag,
    output logic [W-1:0]            o_data
);

    hfs_pkg::t_tag          r_tag  [hfs_pkg::QDEPTH];
    logic [W-1:0]           r_data [hfs_pkg::QDEPTH];
    logic [hfs_pkg::QAW-1:0] r_head, r_tail;
    logic [hfs_pkg::QCW-1:0] r_count;
    logic [hfs_pkg::QAW-1:0] w_tail1;
    logic [hfs_pkg::QCW-1:0] w_npush;

    assign w_tail1 = r_tail + hfs_pkg::QAW'(1);
    // second write port is only used together with the first
    assign w_npush = i_we0 ? (i_we1 ? hfs_pkg::QCW'(2) : hfs_pkg::QCW'(1))
                           : hfs_pkg::QCW'(0);

    always_ff @(posedge i_clk) begin
        if (i_we0) begin
            r_tag[r_tail]  <= i_tag0;
            r_data[r_tail] <= i_data0;
        end
        if (i_we0 && i_we1) begin
            r_tag[w_tail1]  <= i_tag1;
            r_data[w_tail1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + hfs_pkg::QAW'(w_npush);
            if (i_pop) begin
                r_head <= r_head + hfs_pkg::QAW'(1);
            end
            r_count <= r_count + w_npush - hfs_pkg::QCW'(i_pop);
        end
    end

    assign o_count = r_count;
    assign o_tag   = r_tag[r_head];
    assign o_data  = r_data[r_head];

endmodule

>>> design/hfs_front.sv
module hfs_front #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [hfs_pkg::ROWCNT_BITS-1:0] i_row_count,
    input  logic [hfs_pkg::COLCNT_BITS-1:0] i_col_count,
    input  logic [hfs_pkg::QCW-1:0]         i_task_count,
    output logic                            o_we0,
    output logic                            o_we1,
    output hfs_pkg::t_tag                   o_tag0,
    output hfs_pkg::t_tag                   o_tag1,
    output logic [5*SAMPLE_BITS-1:0]        o_data0,
    output logic [5*SAMPLE_BITS-1:0]        o_data1
);

    localparam int SB  = SAMPLE_BITS;
    localparam int DW  = 2 * SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_COLS);
    localparam int CCW = (CW + 1 > hfs_pkg::COLCNT_BITS) ? CW + 1 : hfs_pkg::COLCNT_BITS;
    localparam int RW  = hfs_pkg::ROW_BITS;
    localparam int RCW = hfs_pkg::ROWCNT_BITS;

    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic bnd_a;
        logic glast_b;
    } t_cls;

    logic          w_accept;
    logic [CCW-1:0] w_cc;
    logic [CW-1:0] w_lastc, w_c;
    logic [RW-1:0] w_lastr;
    logic          w_last_col, w_flush, w_emit_ok;
    t_cls          w_cls;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_primed;

    // line buffer entry: {row above, center row}
    logic [DW-1:0] r_line [MAX_COLS];
    logic [DW-1:0] r_rd;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_addr;
    logic [SB-1:0] r_s1_sample;
    t_cls          r_s1_cls;

    logic [SB-1:0] r_win1, r_win2, r_up, r_dn;
    logic [SB-1:0] w_m;
    logic [5*SB-1:0] w_data_a, w_data_b;
    hfs_pkg::t_tag w_tag_a, w_tag_b;

    // room for two tasks of the item in flight plus two of the new one
    assign o_full   = i_task_count > hfs_pkg::QCW'(hfs_pkg::QDEPTH - 4);
    assign w_accept = i_push && !o_full;

    assign w_cc = CCW'(i_col_count);

    always_comb begin
        if (w_cc < CCW'(3)) begin
            w_lastc = CW'(2);
        end else if (w_cc > CCW'(MAX_COLS)) begin
            w_lastc = CW'(MAX_COLS - 1);
        end else begin
            w_lastc = CW'(w_cc - CCW'(1));
        end
        if (i_row_count < RCW'(3)) begin
            w_lastr = RW'(2);
        end else if (i_row_count > RCW'(hfs_pkg::ROW_CAP)) begin
            w_lastr = RW'(hfs_pkg::ROW_CAP - 1);
        end else begin
            w_lastr = RW'(i_row_count - RCW'(1));
        end
    end

    assign w_c        = (r_col > w_lastc) ? w_lastc : r_col;
    assign w_last_col = (w_c == w_lastc);
    assign w_flush    = (r_row == '0);
    // row 0 of the first frame has no earlier row to flush
    assign w_emit_ok  = !w_flush || r_primed;

    always_comb begin
        w_cls.emit_a  = w_emit_ok && (w_c != '0);
        w_cls.emit_b  = w_emit_ok && w_last_col;
        w_cls.bnd_a   = w_flush || (r_row == RW'(1)) || (w_c == CW'(1));
        w_cls.glast_b = w_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_primed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                if (w_last_col) begin
                    r_col <= '0;
                    if (r_row >= w_lastr) begin
                        r_row    <= '0;
                        r_primed <= 1'b1;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= w_c + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr   <= w_c;
            r_s1_sample <= i_sample;
            r_s1_cls    <= w_cls;
        end
    end

    // read on accept, write back in the following cycle; the write can collide
    // with the next read only if the column count drops mid-row
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_line[w_c];
        end
        if (r_s1_valid) begin
            r_line[r_s1_addr] <= {r_rd[SB-1:0], r_s1_sample};
        end
    end

    assign w_m = r_rd[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win1 <= r_win2;
            r_win2 <= w_m;
            r_up   <= r_rd[DW-1:SB];
            r_dn   <= r_s1_sample;
        end
    end

    // task a: point one column back, task b: last column pass-through
    assign w_data_a = {r_win2, r_up, r_dn, r_win1, w_m};
    assign w_data_b = {w_m, r_up, r_dn, r_win1, w_m};

    always_comb begin
        w_tag_a.bnd       = r_s1_cls.bnd_a;
        w_tag_a.run_last  = !r_s1_cls.emit_b;
        w_tag_a.grid_last = 1'b0;
        w_tag_b.bnd       = 1'b1;
        w_tag_b.run_last  = 1'b1;
        w_tag_b.grid_last = r_s1_cls.glast_b;
    end

    assign o_we0   = r_s1_valid && (r_s1_cls.emit_a || r_s1_cls.emit_b);
    assign o_we1   = r_s1_valid && r_s1_cls.emit_a && r_s1_cls.emit_b;
    assign o_tag0  = r_s1_cls.emit_a ? w_tag_a : w_tag_b;
    assign o_data0 = r_s1_cls.emit_a ? w_data_a : w_data_b;
    assign o_tag1  = w_tag_b;
    assign o_data1 = w_data_b;

endmodule

>>> design/hfs_back.sv
module hfs_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hfs_pkg::MU_BITS-1:0] i_mu_row,
    input  logic [hfs_pkg::MU_BITS-1:0] i_mu_col,
    input  logic [hfs_pkg::QCW-1:0]     i_task_count,
    input  hfs_pkg::t_tag               i_tag,
    input  logic [5*SAMPLE_BITS-1:0]    i_data,
    output logic                        o_pop,
    input  logic [hfs_pkg::QCW-1:0]     i_out_count,
    output logic                        o_we,
    output hfs_pkg::t_tag               o_tag,
    output logic [SAMPLE_BITS-1:0]      o_value
);

    localparam int SB = SAMPLE_BITS;
    localparam int DRW = SB + 2;
    localparam int PW  = SB + 2 + hfs_pkg::MU_BITS + 1;
    localparam int TW  = PW + 1 - 16;
    localparam int VW  = SB + 5;
    localparam logic [PW:0] RND = {{(PW - 15){1'b0}}, 1'b1, 15'b0};
    localparam logic [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

    logic [SB-1:0] w_u, w_up, w_dn, w_lf, w_rt;
    logic [DRW-1:0] w_dr, w_dc;
    logic [1:0] w_inflight;

    logic                r_v1, r_v2, r_v3;
    hfs_pkg::t_tag       r_tag1, r_tag2, r_tag3;
    logic [SB-1:0]       r_u1, r_u2, r_u3;
    logic signed [DRW-1:0] r_dr1, r_dc1;
    logic [PW-1:0]       r_pr2, r_pc2;
    logic [TW-1:0]       r_t3;

    logic signed [hfs_pkg::MU_BITS:0] w_mur, w_muc;
    logic [PW-1:0] w_pr, w_pc;
    logic [PW:0]   w_sum;
    logic [VW-1:0] w_v;
    logic [SB-1:0] w_sat;

    assign {w_u, w_up, w_dn, w_lf, w_rt} = i_data;

    assign w_inflight = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};
    // every task issued has a guaranteed slot in the result queue
    assign o_pop = (i_task_count != '0)
                && ((hfs_pkg::QCW + 1)'(i_out_count) + (hfs_pkg::QCW + 1)'(w_inflight)
                    < (hfs_pkg::QCW + 1)'(hfs_pkg::QDEPTH));

    // second differences: up + down - 2u, left + right - 2u
    assign w_dr = {{2{w_up[SB-1]}}, w_up} + {{2{w_dn[SB-1]}}, w_dn}
                - {w_u[SB-1], w_u, 1'b0};
    assign w_dc = {{2{w_lf[SB-1]}}, w_lf} + {{2{w_rt[SB-1]}}, w_rt}
                - {w_u[SB-1], w_u, 1'b0};

    assign w_mur = {1'b0, i_mu_row};
    assign w_muc = {1'b0, i_mu_col};
    assign w_pr  = r_dr1 * w_mur;
    assign w_pc  = r_dc1 * w_muc;

    // round half up, then arithmetic shift by 16
    assign w_sum = {r_pr2[PW-1], r_pr2} + {r_pc2[PW-1], r_pc2} + RND;

    assign w_v = {{5{r_u3[SB-1]}}, r_u3} + {{(VW - TW){r_t3[TW-1]}}, r_t3};

    always_comb begin
        if ((&w_v[VW-1:SB-1]) || !(|w_v[VW-1:SB-1])) begin
            w_sat = w_v[SB-1:0];
        end else if (w_v[VW-1]) begin
            w_sat = SMIN;
        end else begin
            w_sat = SMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_u1   <= w_u;
        r_dr1  <= w_dr;
        r_dc1  <= w_dc;
        r_tag2 <= r_tag1;
        r_u2   <= r_u1;
        r_pr2  <= w_pr;
        r_pc2  <= w_pc;
        r_tag3 <= r_tag2;
        r_u3   <= r_u2;
        r_t3   <= w_sum[PW:16];
    end

    assign o_we    = r_v3;
    assign o_tag   = r_tag3;
    assign o_value = r_tag3.bnd ? r_u3 : w_sat;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_COLS = 1024;
    // width of the opening frame; later phases with wider rows read columns past it
    localparam int PRIME_COLS = 300;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [31:0]   value;
        hfs_pkg::t_tag tag;
    } t_grid_point;

    // mirror of the stencil: line buffers, position, window and registers
    class stencil_scoreboard;
        logic signed [31:0] line_above [MAX_COLS];
        logic signed [31:0] line_center [MAX_COLS];
        logic signed [31:0] window [3];
        logic signed [31:0] up_hold;
        logic signed [31:0] down_hold;
        int row_index;
        int col_index;
        bit primed;
        logic [hfs_pkg::MU_BITS-1:0]     mu_row;
        logic [hfs_pkg::MU_BITS-1:0]     mu_col;
        logic [hfs_pkg::ROWCNT_BITS-1:0] row_count;
        logic [hfs_pkg::COLCNT_BITS-1:0] col_count;
        t_grid_point expected_q[$];
        int n_samples;
        int n_points;
        int n_errors;

        function new();
            foreach (line_above[k]) begin
                line_above[k] = '0;
                line_center[k] = '0;
            end
            foreach (window[k]) window[k] = '0;
            up_hold = '0;
            down_hold = '0;
            row_index = 0;
            col_index = 0;
            primed = 1'b0;
            mu_row = '0;
            mu_col = '0;
            row_count = 13'd3;
            col_count = 11'd3;
            n_samples = 0;
            n_points = 0;
            n_errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                hfs_pkg::REG_MU_ROW:    mu_row = val[hfs_pkg::MU_BITS-1:0];
                hfs_pkg::REG_MU_COL:    mu_col = val[hfs_pkg::MU_BITS-1:0];
                hfs_pkg::REG_ROW_COUNT: row_count = val[hfs_pkg::ROWCNT_BITS-1:0];
                hfs_pkg::REG_COL_COUNT: col_count = val[hfs_pkg::COLCNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // exact weighted sum, rounded half up after the q0.16 scale, then clamped
        function logic [31:0] diffuse(longint u, longint up, longint dn, longint lf, longint rt);
            longint acc;
            longint v;
            acc = longint'(mu_row) * (up + dn - 2 * u) + longint'(mu_col) * (lf + rt - 2 * u);
            v = u + ((acc + 64'sd32768) >>> 16);
            if (v > SAT_HI) v = SAT_HI;
            if (v < SAT_LO) v = SAT_LO;
            return v[31:0];
        endfunction

        function void note_sample(logic [31:0] s);
            int cols;
            int rows;
            int c;
            int r;
            int lastc;
            int n;
            logic signed [31:0] a;
            logic signed [31:0] m;
            bit last_col;
            bit flush;
            t_grid_point pts [2];
            cols = col_count;
            if (cols < 3) cols = 3;
            if (cols > MAX_COLS) cols = MAX_COLS;
            rows = row_count;
            if (rows < 3) rows = 3;
            if (rows > hfs_pkg::ROW_CAP) rows = hfs_pkg::ROW_CAP;
            lastc = cols - 1;
            c = (col_index > lastc) ? lastc : col_index;
            r = row_index;
            last_col = (c == lastc);
            n = 0;
            n_samples++;

            a = line_above[c];
            m = line_center[c];
            window[0] = window[1];
            window[1] = window[2];
            window[2] = m;
            line_above[c] = m;
            line_center[c] = s;

            // row 0 drains the last row of the previous frame, if there was one
            flush = (r == 0);
            if (!flush || primed) begin
                if (c >= 1) begin
                    pts[n] = '0;
                    if (flush || r == 1 || c == 1) begin
                        pts[n].value = window[1];
                        pts[n].tag.bnd = 1'b1;
                    end else begin
                        pts[n].value = diffuse(window[1], up_hold, down_hold,
                                               window[0], window[2]);
                    end
                    n++;
                end
                if (last_col) begin
                    pts[n] = '0;
                    pts[n].value = window[2];
                    pts[n].tag.bnd = 1'b1;
                    pts[n].tag.grid_last = flush;
                    n++;
                end
                if (n > 0) pts[n-1].tag.run_last = 1'b1;
                for (int k = 0; k < n; k++) expected_q.push_back(pts[k]);
            end
            up_hold = a;
            down_hold = s;

            if (last_col) begin
                col_index = 0;
                if (r >= rows - 1) begin
                    row_index = 0;
                    primed = 1'b1;
                end else begin
                    row_index = r + 1;
                end
            end else begin
                col_index = c + 1;
            end
        endfunction

        function void check_point(t_grid_point got);
            t_grid_point exp_pt;
            n_points++;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: value %h", got.value);
                n_errors++;
                return;
            end
            exp_pt = expected_q.pop_front();
            if (got.value !== exp_pt.value) begin
                $error("value: expected %h, got %h", exp_pt.value, got.value);
                n_errors++;
            end
            if (got.tag.bnd !== exp_pt.tag.bnd) begin
                $error("is_boundary: expected %b, got %b", exp_pt.tag.bnd, got.tag.bnd);
                n_errors++;
            end
            if (got.tag.run_last !== exp_pt.tag.run_last) begin
                $error("run_last: expected %b, got %b", exp_pt.tag.run_last, got.tag.run_last);
                n_errors++;
            end
            if (got.tag.grid_last !== exp_pt.tag.grid_last) begin
                $error("grid_last: expected %b, got %b",
                       exp_pt.tag.grid_last, got.tag.grid_last);
                n_errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic [31:0]                   i_sample = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [31:0]                   o_value;
    logic                          o_is_boundary;
    logic                          o_run_last;
    logic                          o_grid_last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [hfs_pkg::APB_AW-1:0]    paddr = '0;
    logic [hfs_pkg::APB_DW-1:0]    pwdata = '0;
    logic [hfs_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    stencil_scoreboard sb = new();
    int send_pct = 0;
    int stall_pct = 0;
    int n_settings = 0;

    heat_ftcs_stencil_2d u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_value       (o_value),
        .o_is_boundary (o_is_boundary),
        .o_run_last    (o_run_last),
        .o_grid_last   (o_grid_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_mu();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // setup then access phase; back-to-back writes keep psel high
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [15:0] mr, input logic [15:0] mc,
                                 input logic [12:0] rc, input logic [10:0] cc);
        reg_write(hfs_pkg::REG_MU_ROW, 32'(mr));
        reg_write(hfs_pkg::REG_MU_COL, 32'(mc));
        reg_write(hfs_pkg::REG_ROW_COUNT, 32'(rc));
        reg_write(hfs_pkg::REG_COL_COUNT, 32'(cc));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_settings++;
    endtask

    task automatic send_sample(input logic [31:0] s);
        if (send_pct != 0 && $urandom_range(1, 100) <= send_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (full);
        sb.note_sample(s);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // row 0 of a fresh frame leaves nothing to wait for, so give the pipe time
    task automatic settle();
        wait_drained();
        repeat (12) @(posedge i_clk);
    endtask

    initial begin : result_side
        t_grid_point got;
        wait (i_rst_n === 1'b1);
        forever begin
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (pop && !empty) begin
                got.value = o_value;
                got.tag.bnd = o_is_boundary;
                got.tag.run_last = o_run_last;
                got.tag.grid_last = o_grid_last;
                sb.check_point(got);
            end
        end
    end

    initial begin : main_flow
        logic [31:0] directed [24];
        logic [12:0] rc;
        logic [10:0] cc;
        int sel;
        int n_items;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one full frame first, PRIME_COLS columns wide and three rows deep
        send_pct = pick_pct();
        stall_pct = pick_pct();
        apply_setting(pick_mu(), pick_mu(), 13'd3, 11'(PRIME_COLS));
        repeat (3 * PRIME_COLS) send_sample(pick_sample());

        // saturation both ways, then half-lsb ties on either sign
        directed = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h0005_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000,
                     32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000,
                     32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000};
        settle();
        apply_setting(16'hFFFF, 16'hFFFF, 13'd3, 11'd4);
        for (int k = 0; k < 12; k++) send_sample(directed[k]);
        settle();
        // row count of zero acts as the minimum
        apply_setting(16'h8000, 16'h0000, 13'd0, 11'd4);
        for (int k = 12; k < 24; k++) send_sample(directed[k]);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            sel = (ph < 6) ? ph : $urandom_range(0, 5);
            case (sel)
                0: begin rc = 13'(hfs_pkg::ROW_CAP); cc = 11'd3; end
                1: begin rc = 13'd3; cc = 11'd1024; end
                2: begin rc = 13'h1FFF; cc = 11'($urandom_range(4, 9)); end
                3: begin rc = 13'($urandom_range(0, 2)); cc = 11'($urandom_range(0, 2)); end
                4: begin rc = 13'($urandom_range(3, 12)); cc = 11'h7FF; end
                default: begin
                    rc = 13'($urandom_range(3, 40));
                    cc = 11'($urandom_range(3, 40));
                end
            endcase
            send_pct = (ph == 7) ? 0 : pick_pct();
            stall_pct = (ph == 7) ? 0 : pick_pct();
            apply_setting(pick_mu(), pick_mu(), rc, cc);
            n_items = 120;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 2 && k == n_items / 2) wait_drained();
                send_sample(pick_sample());
            end
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        $display("run covered %0d samples and %0d result points over %0d register settings",
                 sb.n_samples, sb.n_points, n_settings);
        $display("row widths of 3 to 1024 columns, frames up to 4096 rows, clamped counts, "
                 , "saturation, ties");
        if (sb.n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
